/* rtl/ordl_pkg.sv */
// Shared types and constants for the ordered array list.
`timescale 1ns / 1ps
`default_nettype none

package ordl_pkg;

  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned FPOS_W = 4;
  localparam int unsigned LEN_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_GET    = 3'd1,
    CMD_LOCATE = 3'd2,
    CMD_INSERT = 3'd3,
    CMD_DELETE = 3'd4,
    CMD_PREV   = 3'd5,
    CMD_NEXT   = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              ok;
    logic [VAL_W-1:0]  value;
    logic [FPOS_W-1:0] fpos;
    logic [LEN_W-1:0]  length;
    logic              empty;
  } res_t;

endpackage

`default_nettype wire

/* rtl/ordl_mem.sv */
// Entry store: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ordl_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output      logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* rtl/ordl_seq.sv */
// Command sequencer: range checks, memory sweeps for shift and search, entry count.
`timescale 1ns / 1ps
`default_nettype none

module ordl_seq #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned AW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic [ordl_pkg::CMD_W-1:0]  command_i,
  input  wire logic [ordl_pkg::POS_W-1:0]  position_i,
  input  wire logic [ordl_pkg::VAL_W-1:0]  value_i,
  output      logic                        wr_en_o,
  output      logic [AW-1:0]               wr_addr_o,
  output      logic [DATA_WIDTH-1:0]       wr_data_o,
  output      logic                        rd_en_o,
  output      logic [AW-1:0]               rd_addr_o,
  input  wire logic [DATA_WIDTH-1:0]       rd_data_i,
  output      logic                        res_valid_o,
  input  wire logic                        res_ready_i,
  output      ordl_pkg::res_t              res_o
);
  import ordl_pkg::*;

  localparam int unsigned PW = ((CW > POS_W) ? CW : POS_W) + 1;

  state_e                state_q, state_d;
  cmd_e                  cmd_q, cmd_d;
  logic [PW-1:0]         pos_q, pos_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [CW-1:0]         r_q, r_d;
  logic                  p_vld_q, p_vld_d;
  logic [AW-1:0]         p_idx_q, p_idx_d;
  logic                  ok_q, ok_d;
  logic [DATA_WIDTH-1:0] vout_q, vout_d;
  logic [AW-1:0]         fpos_q, fpos_d;
  logic [CW-1:0]         count_q, count_d;

  logic [PW-1:0]               pos_ext;
  logic [PW-1:0]               cnt_ext;
  logic [PW-1:0]               addr_ext;
  logic [CW-1:0]               r_m1;
  logic [DATA_WIDTH+VAL_W-1:0] val_wide;
  logic [VAL_W+DATA_WIDTH-1:0] vout_wide;
  logic [FPOS_W+AW-1:0]        fpos_wide;
  logic [LEN_W+CW-1:0]         len_wide;

  assign pos_ext  = PW'(position_i);
  assign cnt_ext  = PW'(count_q);
  assign r_m1     = r_q - CW'(1);
  assign val_wide = {{DATA_WIDTH{1'b0}}, value_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      p_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      p_vld_q <= p_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    pos_q   <= pos_d;
    val_q   <= val_d;
    r_q     <= r_d;
    p_idx_q <= p_idx_d;
    ok_q    <= ok_d;
    vout_q  <= vout_d;
    fpos_q  <= fpos_d;
  end

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    pos_d     = pos_q;
    val_d     = val_q;
    r_d       = r_q;
    p_vld_d   = p_vld_q;
    p_idx_d   = p_idx_q;
    ok_d      = ok_q;
    vout_d    = vout_q;
    fpos_d    = fpos_q;
    count_d   = count_q;
    addr_ext  = '0;
    rd_en_o   = 1'b0;
    rd_addr_o = '0;
    wr_en_o   = 1'b0;
    wr_addr_o = '0;
    wr_data_o = '0;
    in_stall_o  = (state_q != ST_IDLE);
    res_valid_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = cmd_e'(command_i);
          pos_d   = pos_ext;
          val_d   = val_wide[DATA_WIDTH-1:0];
          ok_d    = 1'b0;
          vout_d  = '0;
          fpos_d  = '0;
          p_vld_d = 1'b0;
          state_d = ST_DONE;
          case (cmd_e'(command_i))
            CMD_CLEAR: begin
              count_d = '0;
              ok_d    = 1'b1;
            end
            CMD_GET, CMD_PREV, CMD_NEXT: begin
              if (cmd_e'(command_i) == CMD_GET) begin
                addr_ext = pos_ext;
                p_vld_d  = (pos_ext < cnt_ext);
              end else if (cmd_e'(command_i) == CMD_PREV) begin
                addr_ext = pos_ext - PW'(1);
                p_vld_d  = (pos_ext != '0) && (pos_ext <= cnt_ext);
              end else begin
                addr_ext = pos_ext + PW'(1);
                p_vld_d  = (addr_ext < cnt_ext);
              end
              if (p_vld_d) begin
                rd_en_o   = 1'b1;
                rd_addr_o = addr_ext[AW-1:0];
                state_d   = ST_RUN;
              end
            end
            CMD_LOCATE: begin
              r_d     = '0;
              state_d = ST_RUN;
            end
            CMD_INSERT: begin
              if ((pos_ext <= cnt_ext) && (cnt_ext < PW'(CAPACITY))) begin
                r_d     = count_q;
                state_d = ST_RUN;
              end
            end
            CMD_DELETE: begin
              if (pos_ext < cnt_ext) begin
                r_d     = CW'(pos_ext);
                state_d = ST_RUN;
              end
            end
            default: begin
              ok_d = 1'b0;
            end
          endcase
        end
      end

      ST_RUN: begin
        p_vld_d = 1'b0;
        case (cmd_q)
          CMD_LOCATE: begin
            if (p_vld_q && (rd_data_i == val_q)) begin
              ok_d    = 1'b1;
              fpos_d  = p_idx_q;
              state_d = ST_DONE;
            end else if (r_q < count_q) begin
              rd_en_o   = 1'b1;
              rd_addr_o = r_q[AW-1:0];
              p_vld_d   = 1'b1;
              p_idx_d   = r_q[AW-1:0];
              r_d       = r_q + CW'(1);
            end else if (!p_vld_q) begin
              state_d = ST_DONE;
            end
          end
          CMD_INSERT: begin
            // shift up, top entry first
            if (p_vld_q) begin
              wr_en_o   = 1'b1;
              wr_addr_o = p_idx_q + AW'(1);
              wr_data_o = rd_data_i;
            end
            if (PW'(r_q) > pos_q) begin
              rd_en_o   = 1'b1;
              rd_addr_o = r_m1[AW-1:0];
              p_vld_d   = 1'b1;
              p_idx_d   = r_m1[AW-1:0];
              r_d       = r_m1;
            end else if (!p_vld_q) begin
              wr_en_o   = 1'b1;
              wr_addr_o = pos_q[AW-1:0];
              wr_data_o = val_q;
              count_d   = count_q + CW'(1);
              ok_d      = 1'b1;
              state_d   = ST_DONE;
            end
          end
          CMD_DELETE: begin
            // first read returns the removed entry, the rest shift down
            if (p_vld_q) begin
              if (PW'(p_idx_q) == pos_q) begin
                vout_d = rd_data_i;
              end else begin
                wr_en_o   = 1'b1;
                wr_addr_o = p_idx_q - AW'(1);
                wr_data_o = rd_data_i;
              end
            end
            if (r_q < count_q) begin
              rd_en_o   = 1'b1;
              rd_addr_o = r_q[AW-1:0];
              p_vld_d   = 1'b1;
              p_idx_d   = r_q[AW-1:0];
              r_d       = r_q + CW'(1);
            end else if (!p_vld_q) begin
              count_d = count_q - CW'(1);
              ok_d    = 1'b1;
              state_d = ST_DONE;
            end
          end
          default: begin
            if (p_vld_q) begin
              vout_d  = rd_data_i;
              ok_d    = 1'b1;
              state_d = ST_DONE;
            end
          end
        endcase
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign vout_wide = {{VAL_W{1'b0}}, vout_q};
  assign fpos_wide = {{FPOS_W{1'b0}}, fpos_q};
  assign len_wide  = {{LEN_W{1'b0}}, count_q};

  always_comb begin
    res_o.ok     = ok_q;
    res_o.value  = vout_wide[VAL_W-1:0];
    res_o.fpos   = fpos_wide[FPOS_W-1:0];
    res_o.length = len_wide[LEN_W-1:0];
    res_o.empty  = (count_q == '0);
  end

endmodule

`default_nettype wire

/* rtl/ordl_obuf.sv */
// Result output register: holds one beat while the consumer stalls.
`timescale 1ns / 1ps
`default_nettype none

module ordl_obuf (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           res_valid_i,
  output      logic           res_ready_o,
  input  wire ordl_pkg::res_t res_i,
  output      logic           out_valid_o,
  input  wire logic           out_stall_i,
  output      ordl_pkg::res_t out_o
);
  import ordl_pkg::*;

  logic out_valid_q, out_valid_d;
  res_t res_q, res_d;

  assign res_ready_o = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (res_valid_i && res_ready_o) begin
      out_valid_d = 1'b1;
      res_d       = res_i;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = res_q;

endmodule

`default_nettype wire

/* rtl/ordered_array_list.sv */
// Ordered array list top level: entry store, command sequencer and output register.
//
// A fixed-capacity list of signed words kept in a single-port-write,
// single-port-read memory with registered read data. One command is
// handled at a time; in_stall_o is high from the accepted beat until its
// result is handed to the output register, which then holds it while
// out_stall_i is high and lets the next command in meanwhile. Clear and
// refused commands go straight to the output register; get, previous and
// next read one entry; locate reads entries from the first until a match
// or the length, and insert and delete shift the entries from the position
// upward. The memory port reads one entry per cycle during a shift or a
// search and, during a shift, also rewrites one. Entries are not cleared
// at reset; only entries below the length are ever read.
`timescale 1ns / 1ps
`default_nettype none

module ordered_array_list #(
  parameter int unsigned CAPACITY   = ordl_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = ordl_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic [ordl_pkg::CMD_W-1:0]  command_i,
  input  wire logic [ordl_pkg::POS_W-1:0]  position_in_i,
  input  wire logic [ordl_pkg::VAL_W-1:0]  value_in_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      logic                        ok_o,
  output      logic [ordl_pkg::VAL_W-1:0]  value_out_o,
  output      logic [ordl_pkg::FPOS_W-1:0] found_position_o,
  output      logic [ordl_pkg::LEN_W-1:0]  length_out_o,
  output      logic                        empty_out_o
);
  import ordl_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  res_valid;
  logic                  res_ready;
  res_t                  res;
  res_t                  out;

  ordl_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ordl_seq #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .position_i  (position_in_i),
    .value_i     (value_in_i),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  ordl_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out)
  );

  assign ok_o             = out.ok;
  assign value_out_o      = out.value;
  assign found_position_o = out.fpos;
  assign length_out_o     = out.length;
  assign empty_out_o      = out.empty;

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Testbench for ordered_array_list: directed and random commands checked against a list model.
`timescale 1ns / 1ps

module tb_top;
  import ordl_pkg::*;

  localparam int DEPTH = CAPACITY_DEF;
  localparam logic [CMD_W-1:0] CMD_BAD = 3'd7;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic [CMD_W-1:0]  command_i     = '0;
  logic [POS_W-1:0]  position_in_i = '0;
  logic [VAL_W-1:0]  value_in_i    = '0;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic              ok_o;
  logic [VAL_W-1:0]  value_out_o;
  logic [FPOS_W-1:0] found_position_o;
  logic [LEN_W-1:0]  length_out_o;
  logic              empty_out_o;

  logic [VAL_W-1:0] list_mem [DEPTH];
  int               list_len = 0;
  res_t             result_q [$];
  int               error_cnt = 0;
  bit               idle_en = 1'b1;
  int               hold_left = 0;

  ordered_array_list i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .position_in_i    (position_in_i),
    .value_in_i       (value_in_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .ok_o             (ok_o),
    .value_out_o      (value_out_o),
    .found_position_o (found_position_o),
    .length_out_o     (length_out_o),
    .empty_out_o      (empty_out_o)
  );

  always #2 clk_i = ~clk_i;

  // applies one command to the list copy and returns the result it gives
  function automatic res_t list_apply(input logic [CMD_W-1:0] cmd,
                                      input logic [POS_W-1:0] pos,
                                      input logic [VAL_W-1:0] val);
    res_t r;
    int   p;
    r = '0;
    p = pos;
    case (cmd)
      CMD_CLEAR: begin
        list_len = 0;
        r.ok = 1'b1;
      end
      CMD_GET: begin
        if (p < list_len) begin
          r.value = list_mem[p];
          r.ok = 1'b1;
        end
      end
      CMD_LOCATE: begin
        for (int i = 0; i < list_len; i++) begin
          if (!r.ok && list_mem[i] == val) begin
            r.ok = 1'b1;
            r.fpos = FPOS_W'(i);
          end
        end
      end
      CMD_INSERT: begin
        if (p <= list_len && list_len < DEPTH) begin
          for (int i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p] = val;
          list_len++;
          r.ok = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (p < list_len) begin
          r.value = list_mem[p];
          for (int i = p + 1; i < list_len; i++) list_mem[i-1] = list_mem[i];
          list_len--;
          r.ok = 1'b1;
        end
      end
      CMD_PREV: begin
        if (p >= 1 && p <= list_len) begin
          r.value = list_mem[p-1];
          r.ok = 1'b1;
        end
      end
      CMD_NEXT: begin
        if (p + 1 < list_len) begin
          r.value = list_mem[p+1];
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.length = list_len[LEN_W-1:0];
    r.empty  = (list_len == 0);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                             input logic [VAL_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_cnt++;
    end
  endtask

  // result side: check each beat, drive stall
  always @(posedge clk_i) begin : rx_side
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (result_q.size() == 0) begin
        $error("result beat with no command pending");
        error_cnt++;
      end else begin
        want = result_q.pop_front();
        check_field("ok", VAL_W'(want.ok), VAL_W'(ok_o));
        check_field("value_out", want.value, value_out_o);
        check_field("found_position", VAL_W'(want.fpos), VAL_W'(found_position_o));
        check_field("length_out", VAL_W'(want.length), VAL_W'(length_out_o));
        check_field("empty_out", VAL_W'(want.empty), VAL_W'(empty_out_o));
      end
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall_i <= idle_en && ($urandom_range(99) < 26);
    end
  end

  // leaves valid high after the beat so a following command goes out back to back
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                          input logic [VAL_W-1:0] val);
    while (idle_en && $urandom_range(99) < 26) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    position_in_i <= pos;
    value_in_i    <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    result_q.push_back(list_apply(cmd, pos, val));
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (result_q.size() != 0);
  endtask

  task automatic send_random();
    int               pick;
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    pick = $urandom_range(99);
    if (pick < 2) cmd = CMD_CLEAR;
    else if (pick < 4) cmd = CMD_BAD;
    else if (pick < 34) cmd = CMD_INSERT;
    else if (pick < 54) cmd = CMD_DELETE;
    else if (pick < 66) cmd = CMD_GET;
    else if (pick < 78) cmd = CMD_LOCATE;
    else if (pick < 89) cmd = CMD_PREV;
    else cmd = CMD_NEXT;
    if ($urandom_range(99) < 85) pos = POS_W'($urandom_range(0, list_len));
    else pos = POS_W'($urandom_range(0, DEPTH));
    pick = $urandom_range(99);
    if (pick < 10) begin
      case ($urandom_range(3))
        0: val = '0;
        1: val = '1;
        2: val = 32'h7FFF_FFFF;
        default: val = 32'h8000_0000;
      endcase
    end else if (pick < 40) begin
      val = $urandom_range(0, 7);
    end else begin
      val = $urandom;
    end
    if (cmd == CMD_LOCATE && list_len > 0 && $urandom_range(99) < 60)
      val = list_mem[$urandom_range(0, list_len - 1)];
    send_cmd(cmd, pos, val);
  endtask

  task automatic test_empty_list();
    send_cmd(CMD_CLEAR, 0, 0);
    send_cmd(CMD_GET, 0, 0);
    send_cmd(CMD_DELETE, 0, 0);
    send_cmd(CMD_PREV, 0, 0);
    send_cmd(CMD_NEXT, 0, 0);
    send_cmd(CMD_LOCATE, 0, 0);
    send_cmd(CMD_BAD, 5'd16, '1);
    send_cmd(CMD_INSERT, 1, 32'h1);
  endtask

  task automatic test_bounds();
    send_cmd(CMD_INSERT, 0, 32'h7FFF_FFFF);
    send_cmd(CMD_INSERT, 0, 32'h8000_0000);
    send_cmd(CMD_INSERT, 2, 32'h8000_0000);
    send_cmd(CMD_LOCATE, 0, 32'h8000_0000);
    send_cmd(CMD_LOCATE, 0, 32'h0000_0005);
    send_cmd(CMD_PREV, 3, 0);
    send_cmd(CMD_PREV, 4, 0);
    send_cmd(CMD_NEXT, 1, 0);
    send_cmd(CMD_NEXT, 2, 0);
    send_cmd(CMD_GET, 3, 0);
    send_cmd(CMD_DELETE, 1, 0);
    send_cmd(CMD_DELETE, 2, 0);
  endtask

  task automatic test_full_list();
    while (list_len < DEPTH)
      send_cmd(CMD_INSERT, POS_W'($urandom_range(0, list_len)), $urandom);
    send_cmd(CMD_INSERT, 0, 32'hFFFF_FFFF);
    send_cmd(CMD_GET, 15, 0);
    send_cmd(CMD_NEXT, 14, 0);
    send_cmd(CMD_PREV, 16, 0);
    send_cmd(CMD_LOCATE, 0, list_mem[15]);
    send_cmd(CMD_DELETE, 15, 0);
    send_cmd(CMD_CLEAR, 0, 0);
  endtask

  // long result stall: the block fills and stalls its input
  task automatic test_output_hold();
    hold_left <= 200;
    repeat (12) send_random();
    wait_drain();
  endtask

  task automatic test_random(input int n);
    for (int k = 0; k < n; k++) begin
      idle_en = !(k >= n / 3 && k < n / 3 + 200);
      if (k == n / 2) wait_drain();
      send_random();
    end
    idle_en = 1'b1;
    wait_drain();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_bounds();
    test_full_list();
    test_output_hold();
    test_random(1500);
    repeat (40) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
